### design/pfe_pkg.sv
`timescale 1ns / 1ps

package pfe_pkg;

    localparam int ARG_WIDTH_DEF = 32;
    localparam int QUEUE_DEPTH   = 2;
    localparam int COUNT_W       = 32;
    localparam int NULL_LEN      = 6;

    // Request type codes
    localparam logic [1:0] RT_FMT  = 2'd0;
    localparam logic [1:0] RT_ARG  = 2'd1;
    localparam logic [1:0] RT_SBYTE = 2'd2;
    localparam logic [1:0] RT_SEND = 2'd3;

    // Characters
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_A_LOW = 8'h61;
    localparam logic [7:0] CH_C     = 8'h63;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_X     = 8'h78;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_PCT,
        PH_ARG,
        PH_STR
    } phase_t;

    typedef enum logic [1:0] {
        KD_CHR,
        KD_DEC,
        KD_UNS,
        KD_HEX
    } kind_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_DUMMY,
        BK_PCT,
        BK_CHAR,
        BK_NULL,
        BK_SIGN,
        BK_CONV,
        BK_SKIP,
        BK_DIGIT
    } bk_state_t;

    // Work for the back end; the argument value travels beside it
    typedef struct packed {
        logic       pct;      // print '%' first
        logic       chr;      // print chr_val
        logic [7:0] chr_val;
        logic       nul;      // print "(null)"
        logic       num;      // print the value as a number
        logic       neg;      // print '-' before the number
        logic       hex;      // base 16, else base 10
        logic       dummy;    // one uncounted zero character
        logic       fin;      // format ends with this request
        logic       bad;      // request was dropped
    } job_t;

    function automatic logic [7:0] null_char(input logic [2:0] idx);
        logic [7:0] c;
        begin
            unique case (idx)
                3'd0:    c = 8'h28;
                3'd1:    c = 8'h6e;
                3'd2:    c = 8'h75;
                3'd3:    c = 8'h6c;
                3'd4:    c = 8'h6c;
                default: c = 8'h29;
            endcase
            return c;
        end
    endfunction

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        begin
            if (d < 4'd10)
            begin
                return CH_ZERO + {4'b0000, d};
            end
            return CH_A_LOW + {4'b0000, d} - 8'd10;
        end
    endfunction

endpackage

### design/pfe_if.sv
`timescale 1ns / 1ps

interface pfe_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [7:0]  in_byte;
    logic        format_end;
    logic [31:0] arg_value;
    logic        null_string;

    modport source (output valid, req_type, in_byte, format_end, arg_value, null_string,
                    input ready);
    modport sink (input valid, req_type, in_byte, format_end, arg_value, null_string,
                  output ready);
endinterface

interface pfe_res_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_char;
    logic        out_last;
    logic        done_res;
    logic [31:0] total_count;
    logic        status;

    modport source (output valid, out_char, out_last, done_res, total_count, status,
                    input ready);
    modport sink (input valid, out_char, out_last, done_res, total_count, status,
                  output ready);
endinterface

### design/pfe_front.sv
`timescale 1ns / 1ps

module pfe_front #(
    parameter int ARG_WIDTH = pfe_pkg::ARG_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    pfe_req_if.sink              req,
    input  logic                 q_full,
    output logic                 q_push,
    output pfe_pkg::job_t        q_job,
    output logic [ARG_WIDTH-1:0] q_value
);

    pfe_pkg::phase_t phase_reg, phase_next;
    pfe_pkg::kind_t  kind_reg, kind_next;
    logic            pend_reg, pend_next;

    logic                 acc;
    logic [ARG_WIDTH-1:0] arg_w;

    assign req.ready = !q_full;
    assign acc       = req.valid && !q_full;
    assign arg_w     = ARG_WIDTH'(req.arg_value);

    // Next state
    always_comb
    begin
        phase_next = phase_reg;
        kind_next  = kind_reg;
        pend_next  = pend_reg;
        if (acc)
        begin
            unique case (phase_reg)
                pfe_pkg::PH_IDLE:
                begin
                    if (req.req_type == pfe_pkg::RT_FMT &&
                        req.in_byte == pfe_pkg::CH_PCT && !req.format_end)
                    begin
                        phase_next = pfe_pkg::PH_PCT;
                    end
                end
                pfe_pkg::PH_PCT:
                begin
                    if (req.req_type == pfe_pkg::RT_FMT)
                    begin
                        pend_next  = req.format_end;
                        phase_next = pfe_pkg::PH_ARG;
                        unique case (req.in_byte)
                            pfe_pkg::CH_C: kind_next = pfe_pkg::KD_CHR;
                            pfe_pkg::CH_D,
                            pfe_pkg::CH_I: kind_next = pfe_pkg::KD_DEC;
                            pfe_pkg::CH_U: kind_next = pfe_pkg::KD_UNS;
                            pfe_pkg::CH_X: kind_next = pfe_pkg::KD_HEX;
                            pfe_pkg::CH_S: phase_next = pfe_pkg::PH_STR;
                            default:
                            begin
                                // not a conversion: parse the byte afresh
                                pend_next = pend_reg;
                                if (req.in_byte == pfe_pkg::CH_PCT && !req.format_end)
                                begin
                                    phase_next = pfe_pkg::PH_PCT;
                                end
                                else
                                begin
                                    phase_next = pfe_pkg::PH_IDLE;
                                end
                            end
                        endcase
                    end
                end
                pfe_pkg::PH_ARG:
                begin
                    if (req.req_type == pfe_pkg::RT_ARG)
                    begin
                        pend_next  = 1'b0;
                        phase_next = pfe_pkg::PH_IDLE;
                    end
                end
                pfe_pkg::PH_STR:
                begin
                    if (req.req_type == pfe_pkg::RT_SEND)
                    begin
                        phase_next = pfe_pkg::PH_IDLE;
                        pend_next  = 1'b0;
                    end
                end
            endcase
        end
    end

    // Queue work
    always_comb
    begin
        q_job   = '0;
        q_value = arg_w;
        q_push  = 1'b0;
        if (acc)
        begin
            unique case (phase_reg)
                pfe_pkg::PH_IDLE:
                begin
                    if (req.req_type != pfe_pkg::RT_FMT)
                    begin
                        q_job.dummy = 1'b1;
                        q_job.bad   = 1'b1;
                        q_push      = 1'b1;
                    end
                    else if (req.in_byte != pfe_pkg::CH_PCT || req.format_end)
                    begin
                        q_job.chr     = 1'b1;
                        q_job.chr_val = req.in_byte;
                        q_job.fin     = req.format_end;
                        q_push        = 1'b1;
                    end
                end
                pfe_pkg::PH_PCT:
                begin
                    if (req.req_type != pfe_pkg::RT_FMT)
                    begin
                        q_job.dummy = 1'b1;
                        q_job.bad   = 1'b1;
                        q_push      = 1'b1;
                    end
                    else
                    begin
                        unique case (req.in_byte)
                            pfe_pkg::CH_C,
                            pfe_pkg::CH_D,
                            pfe_pkg::CH_I,
                            pfe_pkg::CH_U,
                            pfe_pkg::CH_X,
                            pfe_pkg::CH_S:
                            begin
                                // conversion letter: nothing to print yet
                                q_push = 1'b0;
                            end
                            default:
                            begin
                                // print '%' then the byte unless it holds a new '%'
                                q_job.pct = 1'b1;
                                q_push    = 1'b1;
                                if (req.in_byte != pfe_pkg::CH_PCT || req.format_end)
                                begin
                                    q_job.chr     = 1'b1;
                                    q_job.chr_val = req.in_byte;
                                    q_job.fin     = req.format_end;
                                end
                            end
                        endcase
                    end
                end
                pfe_pkg::PH_ARG:
                begin
                    q_push = 1'b1;
                    if (req.req_type != pfe_pkg::RT_ARG)
                    begin
                        q_job.dummy = 1'b1;
                        q_job.bad   = 1'b1;
                    end
                    else
                    begin
                        q_job.fin = pend_reg;
                        unique case (kind_reg)
                            pfe_pkg::KD_CHR:
                            begin
                                q_job.chr     = 1'b1;
                                q_job.chr_val = arg_w[7:0];
                            end
                            pfe_pkg::KD_DEC:
                            begin
                                q_job.num = 1'b1;
                                q_job.neg = arg_w[ARG_WIDTH-1];
                                if (arg_w[ARG_WIDTH-1])
                                begin
                                    q_value = ARG_WIDTH'(~arg_w + 1'b1);
                                end
                            end
                            pfe_pkg::KD_UNS:
                            begin
                                q_job.num = 1'b1;
                            end
                            pfe_pkg::KD_HEX:
                            begin
                                q_job.num = 1'b1;
                                q_job.hex = 1'b1;
                            end
                        endcase
                    end
                end
                pfe_pkg::PH_STR:
                begin
                    if (req.req_type == pfe_pkg::RT_SBYTE)
                    begin
                        q_job.chr     = 1'b1;
                        q_job.chr_val = req.in_byte;
                        q_push        = 1'b1;
                    end
                    else if (req.req_type == pfe_pkg::RT_SEND)
                    begin
                        q_job.fin   = pend_reg;
                        q_job.nul   = req.null_string;
                        // empty string that ends the format still reports the count
                        q_job.dummy = !req.null_string;
                        q_push      = req.null_string || pend_reg;
                    end
                    else
                    begin
                        q_job.dummy = 1'b1;
                        q_job.bad   = 1'b1;
                        q_push      = 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= pfe_pkg::PH_IDLE;
            kind_reg  <= pfe_pkg::KD_CHR;
            pend_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            kind_reg  <= kind_next;
            pend_reg  <= pend_next;
        end
    end

endmodule

### design/pfe_queue.sv
`timescale 1ns / 1ps

module pfe_queue #(
    parameter int ARG_WIDTH = pfe_pkg::ARG_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  pfe_pkg::job_t        push_job,
    input  logic [ARG_WIDTH-1:0] push_value,
    output logic                 full,
    input  logic                 pop,
    output logic                 empty,
    output pfe_pkg::job_t        head_job,
    output logic [ARG_WIDTH-1:0] head_value
);

    localparam int DEPTH = pfe_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    pfe_pkg::job_t        job_mem [DEPTH];
    logic [ARG_WIDTH-1:0] val_mem [DEPTH];

    logic [PTR_W-1:0] wr_reg, wr_next;
    logic [PTR_W-1:0] rd_reg, rd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign full       = (cnt_reg == CNT_W'(DEPTH));
    assign empty      = (cnt_reg == '0);
    assign head_job   = job_mem[rd_reg];
    assign head_value = val_mem[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wr_next = (wr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_next = (rd_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            job_mem[wr_reg] <= push_job;
            val_mem[wr_reg] <= push_value;
        end
    end

endmodule

### design/pfe_back.sv
`timescale 1ns / 1ps

module pfe_back #(
    parameter int ARG_WIDTH = pfe_pkg::ARG_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_empty,
    input  pfe_pkg::job_t        q_job,
    input  logic [ARG_WIDTH-1:0] q_value,
    output logic                 q_pop,
    pfe_res_if.source            res
);

    localparam int NDIG    = (ARG_WIDTH * 302 + 999) / 1000;
    localparam int BCD_W   = 4 * NDIG;
    localparam int REM_W   = $clog2(NDIG + 1);
    localparam int BIT_W   = $clog2(ARG_WIDTH);
    localparam int IDX_W   = $clog2(pfe_pkg::NULL_LEN);
    localparam int COUNT_W = pfe_pkg::COUNT_W;

    pfe_pkg::bk_state_t   state_reg, state_next;
    pfe_pkg::job_t        job_reg, job_next;
    logic [ARG_WIDTH-1:0] val_reg, val_next;
    logic [BCD_W-1:0]     bcd_reg, bcd_next;
    logic [REM_W-1:0]     rem_reg, rem_next;
    logic [BIT_W-1:0]     bit_reg, bit_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [COUNT_W-1:0]   cnt_reg, cnt_next;

    logic                 out_valid_reg, out_valid_next;
    logic [7:0]           out_char_reg, out_char_next;
    logic                 out_last_reg, out_last_next;
    logic                 done_reg, done_next;
    logic [COUNT_W-1:0]   total_reg, total_next;
    logic                 status_reg, status_next;

    logic       free;
    logic [3:0] top_dig;
    logic       skip_zero;

    assign free      = !out_valid_reg || res.ready;
    assign top_dig   = bcd_reg[BCD_W-1 -: 4];
    assign skip_zero = (top_dig == 4'd0) && (rem_reg > REM_W'(1));

    assign res.valid       = out_valid_reg;
    assign res.out_char    = out_char_reg;
    assign res.out_last    = out_last_reg;
    assign res.done_res    = done_reg;
    assign res.total_count = total_reg;
    assign res.status      = status_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pfe_pkg::BK_IDLE:
            begin
                if (!q_empty)
                begin
                    priority if (q_job.dummy) state_next = pfe_pkg::BK_DUMMY;
                    else if (q_job.pct)       state_next = pfe_pkg::BK_PCT;
                    else if (q_job.chr)       state_next = pfe_pkg::BK_CHAR;
                    else if (q_job.nul)       state_next = pfe_pkg::BK_NULL;
                    else if (q_job.neg)       state_next = pfe_pkg::BK_SIGN;
                    else if (q_job.hex)       state_next = pfe_pkg::BK_SKIP;
                    else                      state_next = pfe_pkg::BK_CONV;
                end
            end
            pfe_pkg::BK_DUMMY,
            pfe_pkg::BK_CHAR:
            begin
                if (free)
                begin
                    state_next = pfe_pkg::BK_IDLE;
                end
            end
            pfe_pkg::BK_PCT:
            begin
                if (free)
                begin
                    state_next = job_reg.chr ? pfe_pkg::BK_CHAR : pfe_pkg::BK_IDLE;
                end
            end
            pfe_pkg::BK_NULL:
            begin
                if (free && idx_reg == IDX_W'(pfe_pkg::NULL_LEN - 1))
                begin
                    state_next = pfe_pkg::BK_IDLE;
                end
            end
            pfe_pkg::BK_SIGN:
            begin
                if (free)
                begin
                    state_next = pfe_pkg::BK_CONV;
                end
            end
            pfe_pkg::BK_CONV:
            begin
                if (bit_reg == '0)
                begin
                    state_next = pfe_pkg::BK_SKIP;
                end
            end
            pfe_pkg::BK_SKIP:
            begin
                if (!skip_zero)
                begin
                    state_next = pfe_pkg::BK_DIGIT;
                end
            end
            pfe_pkg::BK_DIGIT:
            begin
                if (free && rem_reg == REM_W'(1))
                begin
                    state_next = pfe_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = pfe_pkg::BK_IDLE;
            end
        endcase
    end

    // Datapath and result register
    always_comb
    begin
        logic               emit;
        logic [7:0]         e_char;
        logic               e_cnt;
        logic               e_last;
        logic               fin_now;
        logic [COUNT_W-1:0] cnt_inc;
        logic [COUNT_W-1:0] cnt_new;
        logic [BCD_W-1:0]   adj;

        emit     = 1'b0;
        e_char   = 8'h00;
        e_cnt    = 1'b1;
        e_last   = 1'b0;
        adj      = bcd_reg;
        q_pop    = 1'b0;
        job_next = job_reg;
        val_next = val_reg;
        bcd_next = bcd_reg;
        rem_next = rem_reg;
        bit_next = bit_reg;
        idx_next = idx_reg;

        unique case (state_reg)
            pfe_pkg::BK_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop    = 1'b1;
                    job_next = q_job;
                    val_next = q_value;
                    bcd_next = q_job.hex ? BCD_W'(q_value) : '0;
                    rem_next = REM_W'(NDIG);
                    bit_next = BIT_W'(ARG_WIDTH - 1);
                    idx_next = '0;
                end
            end
            pfe_pkg::BK_DUMMY:
            begin
                emit   = free;
                e_cnt  = 1'b0;
                e_last = 1'b1;
            end
            pfe_pkg::BK_PCT:
            begin
                emit   = free;
                e_char = pfe_pkg::CH_PCT;
                e_last = !job_reg.chr;
            end
            pfe_pkg::BK_CHAR:
            begin
                emit   = free;
                e_char = job_reg.chr_val;
                e_last = 1'b1;
            end
            pfe_pkg::BK_NULL:
            begin
                emit   = free;
                e_char = pfe_pkg::null_char(3'(idx_reg));
                e_last = (idx_reg == IDX_W'(pfe_pkg::NULL_LEN - 1));
                if (free)
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            pfe_pkg::BK_SIGN:
            begin
                emit   = free;
                e_char = pfe_pkg::CH_MINUS;
            end
            pfe_pkg::BK_CONV:
            begin
                // shift-add-3: correct each digit, then shift one bit in
                for (int i = 0; i < NDIG; i++)
                begin
                    if (bcd_reg[4*i +: 4] >= 4'd5)
                    begin
                        adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
                    end
                end
                bcd_next = {adj[BCD_W-2:0], val_reg[ARG_WIDTH-1]};
                val_next = {val_reg[ARG_WIDTH-2:0], 1'b0};
                bit_next = bit_reg - 1'b1;
            end
            pfe_pkg::BK_SKIP:
            begin
                if (skip_zero)
                begin
                    bcd_next = {bcd_reg[BCD_W-5:0], 4'h0};
                    rem_next = rem_reg - 1'b1;
                end
            end
            pfe_pkg::BK_DIGIT:
            begin
                emit   = free;
                e_char = pfe_pkg::digit_char(top_dig);
                e_last = (rem_reg == REM_W'(1));
                if (free)
                begin
                    bcd_next = {bcd_reg[BCD_W-5:0], 4'h0};
                    rem_next = rem_reg - 1'b1;
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase

        cnt_inc = (cnt_reg == '1) ? cnt_reg : cnt_reg + 1'b1;
        cnt_new = e_cnt ? cnt_inc : cnt_reg;
        fin_now = e_last && job_reg.fin;

        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !res.ready;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        done_next      = done_reg;
        total_next     = total_reg;
        status_next    = status_reg;
        if (emit)
        begin
            cnt_next       = fin_now ? '0 : cnt_new;
            out_valid_next = 1'b1;
            out_char_next  = e_char;
            out_last_next  = e_last;
            done_next      = fin_now;
            total_next     = fin_now ? cnt_new : '0;
            status_next    = job_reg.bad;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pfe_pkg::BK_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            rem_reg       <= '0;
            bit_reg       <= '0;
            idx_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            rem_reg       <= rem_next;
            bit_reg       <= bit_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg      <= job_next;
        val_reg      <= val_next;
        bcd_reg      <= bcd_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
        done_reg     <= done_next;
        total_reg    <= total_next;
        status_reg   <= status_next;
    end

endmodule

### design/printf_format_engine.sv
`timescale 1ns / 1ps
//  channel | modport | payload                                            | accepted when
//  --------+---------+----------------------------------------------------+--------------
//  req     | sink    | req_type, in_byte, format_end, arg_value,          | valid & ready
//          |         | null_string                                        |
//  res     | source  | out_char, out_last, done_res, total_count, status  | valid & ready
//
//  Flow: a request is classified as it is accepted and queued (two entries); the back
//  end pops a job and prints a character, "(null)" or a number. A decimal or unsigned
//  value runs the shift-add-3 conversion after any minus; NDIG = 10 digit slots at 32 bits
//  are each skipped or printed. A held '%' or conversion letter takes no queue entry.
//  Reset: rst_n clears phase, queue pointers, character count and the result valid.
//  Stalls: res.ready low holds the output; the front takes requests until the queue fills.

module printf_format_engine #(
    parameter int ARG_WIDTH = pfe_pkg::ARG_WIDTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    pfe_req_if.sink   req,
    pfe_res_if.source res
);

    // Front to queue
    logic                 q_push;
    pfe_pkg::job_t        q_push_job;
    logic [ARG_WIDTH-1:0] q_push_value;
    logic                 q_full;

    // Queue to back
    logic                 q_pop;
    logic                 q_empty;
    pfe_pkg::job_t        q_head_job;
    logic [ARG_WIDTH-1:0] q_head_value;

    // Classify each request against the parse phase; drop wrong types here
    pfe_front #(
        .ARG_WIDTH (ARG_WIDTH)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_job   (q_push_job),
        .q_value (q_push_value)
    );

    // Decouple classification from character output
    pfe_queue #(
        .ARG_WIDTH (ARG_WIDTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_job   (q_push_job),
        .push_value (q_push_value),
        .full       (q_full),
        .pop        (q_pop),
        .empty      (q_empty),
        .head_job   (q_head_job),
        .head_value (q_head_value)
    );

    // Sequence characters, convert numbers, keep the running count
    pfe_back #(
        .ARG_WIDTH (ARG_WIDTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_job   (q_head_job),
        .q_value (q_head_value),
        .q_pop   (q_pop),
        .res     (res)
    );

endmodule

### bench/pfe_char_checker.sv
`timescale 1ns / 1ps

module pfe_char_checker (
    input  logic clk,
    input  logic rst_n,
    pfe_req_if   req,
    pfe_res_if   res,
    output int   fail_count,
    output int   outstanding
);
    import pfe_pkg::*;

    typedef struct packed {
        logic [7:0]  ch;
        logic        last;
        logic        done;
        logic [31:0] total;
        logic        status;
    } char_exp_t;

    char_exp_t   char_q[$];
    logic [7:0]  line_chars[$];

    phase_t      fmt_phase;
    kind_t       arg_kind;
    logic        end_pending;
    logic [31:0] printed;
    logic        fmt_done;

    function automatic void put_char(input logic [7:0] c);
        line_chars.push_back(c);
        if (printed != '1)
        begin
            printed++;
        end
    endfunction

    function automatic void put_number(input logic [31:0] v, input logic hex);
        logic [7:0] digs[$];
        logic [3:0] d;
        if (v == 32'd0)
        begin
            put_char(CH_ZERO);
            return;
        end
        while (v != 32'd0)
        begin
            d = hex ? v[3:0] : 4'(v % 32'd10);
            digs.push_front((d < 4'd10) ? CH_ZERO + 8'(d) : CH_A_LOW + 8'(d) - 8'd10);
            v = hex ? (v >> 4) : (v / 32'd10);
        end
        foreach (digs[k])
        begin
            put_char(digs[k]);
        end
    endfunction

    function automatic void plain_char(input logic [7:0] b, input logic is_end);
        if (b == CH_PCT && !is_end)
        begin
            fmt_phase = PH_PCT;
            return;
        end
        put_char(b);
        if (is_end)
        begin
            fmt_done = 1'b1;
        end
    endfunction

    function automatic void after_pct(input logic [7:0] b, input logic is_end);
        case (b)
            CH_C:
            begin
                arg_kind  = KD_CHR;
                fmt_phase = PH_ARG;
            end
            CH_D, CH_I:
            begin
                arg_kind  = KD_DEC;
                fmt_phase = PH_ARG;
            end
            CH_U:
            begin
                arg_kind  = KD_UNS;
                fmt_phase = PH_ARG;
            end
            CH_X:
            begin
                arg_kind  = KD_HEX;
                fmt_phase = PH_ARG;
            end
            CH_S:
            begin
                fmt_phase = PH_STR;
            end
            default:
            begin
                // not a conversion: print the held '%' and parse the byte again
                put_char(CH_PCT);
                fmt_phase = PH_IDLE;
                plain_char(b, is_end);
                return;
            end
        endcase
        end_pending = is_end;
    endfunction

    function automatic void take_arg(input logic [31:0] a);
        case (arg_kind)
            KD_CHR: put_char(a[7:0]);
            KD_DEC:
            begin
                if (a[31])
                begin
                    put_char(CH_MINUS);
                    put_number(-a, 1'b0);
                end
                else
                begin
                    put_number(a, 1'b0);
                end
            end
            KD_HEX:  put_number(a, 1'b1);
            default: put_number(a, 1'b0);
        endcase
        if (end_pending)
        begin
            fmt_done = 1'b1;
        end
        fmt_phase = PH_IDLE;
    endfunction

    function automatic void predict_chars(input logic [1:0] rt, input logic [7:0] b,
                                          input logic fe, input logic [31:0] av,
                                          input logic ns);
        logic        bad;
        logic [31:0] total;
        char_exp_t   e;
        bad = 1'b0;
        fmt_done = 1'b0;
        line_chars.delete();
        case (fmt_phase)
            PH_IDLE, PH_PCT:
            begin
                if (rt != RT_FMT)
                    bad = 1'b1;
                else if (fmt_phase == PH_IDLE)
                    plain_char(b, fe);
                else
                    after_pct(b, fe);
            end
            PH_ARG:
            begin
                if (rt != RT_ARG)
                    bad = 1'b1;
                else
                    take_arg(av);
            end
            default:
            begin
                if (rt == RT_SBYTE)
                begin
                    put_char(b);
                end
                else if (rt == RT_SEND)
                begin
                    if (ns)
                    begin
                        put_char("(");
                        put_char("n");
                        put_char("u");
                        put_char("l");
                        put_char("l");
                        put_char(")");
                    end
                    if (end_pending)
                        fmt_done = 1'b1;
                    fmt_phase = PH_IDLE;
                end
                else
                begin
                    bad = 1'b1;
                end
            end
        endcase

        // a dropped request or a silent format end still owes one marker character
        if (line_chars.size() == 0 && (fmt_done || bad))
            line_chars.push_back(8'h00);

        total = printed;
        if (fmt_done)
        begin
            printed     = '0;
            end_pending = 1'b0;
        end

        foreach (line_chars[k])
        begin
            e.ch     = line_chars[k];
            e.last   = (k == line_chars.size() - 1);
            e.done   = e.last && fmt_done;
            e.total  = (e.last && fmt_done) ? total : 32'd0;
            e.status = bad;
            char_q.push_back(e);
        end
    endfunction

    always @(posedge clk)
    begin : watch
        char_exp_t want;
        if (!rst_n)
        begin
            char_q.delete();
            fmt_phase   = PH_IDLE;
            arg_kind    = KD_CHR;
            end_pending = 1'b0;
            printed     = '0;
            fail_count  = 0;
        end
        else
        begin
            if (req.valid && req.ready)
                predict_chars(req.req_type, req.in_byte, req.format_end, req.arg_value,
                              req.null_string);
            if (res.valid && res.ready)
            begin
                if (char_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected character %h last %b done %b count %0d st %b",
                                 $realtime, res.out_char, res.out_last, res.done_res,
                                 res.total_count, res.status);
                end
                else
                begin
                    want = char_q.pop_front();
                    if (res.out_char !== want.ch || res.out_last !== want.last ||
                        res.done_res !== want.done || res.total_count !== want.total ||
                        res.status !== want.status)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t: want %h/%b/%b/%0d/%b got %h/%b/%b/%0d/%b",
                                     $realtime, want.ch, want.last, want.done, want.total,
                                     want.status, res.out_char, res.out_last,
                                     res.done_res, res.total_count, res.status);
                    end
                end
            end
        end
        outstanding = char_q.size();
    end

endmodule

### bench/tb_printf_format_engine.sv
`timescale 1ns / 1ps

module tb_printf_format_engine;
    import pfe_pkg::*;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic rcv_ready = 1'b0;

    // idle odds in percent for the request sender and the character receiver
    int snd_idle = 38;
    int rcv_idle = 76;

    int reqs_sent = 0;
    int fail_count;
    int outstanding;

    pfe_req_if req_ch ();
    pfe_res_if res_ch ();

    assign res_ch.ready = rcv_ready;

    printf_format_engine dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch)
    );

    // The checker watches both channels on its own, predicts every printed
    // character and hands back the failure count and the number of characters
    // still owed by the block.
    pfe_char_checker watch (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .res         (res_ch),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always #5 clk = ~clk;

    // Stall the character side at random; hold ready low through reset.
    always @(posedge clk)
    begin
        rcv_ready <= rst_n && ($urandom_range(99) >= rcv_idle);
    end

    // Present one request and hold it until the block takes it. Idle cycles
    // come first, so valid is only lowered in the step of the last accept and
    // raised in a later one.
    task automatic drive_req(input logic [1:0] rt, input logic [7:0] b, input logic fe,
                             input logic [31:0] av, input logic ns);
        while ($urandom_range(99) < snd_idle)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= rt;
        req_ch.in_byte     <= b;
        req_ch.format_end  <= fe;
        req_ch.arg_value   <= av;
        req_ch.null_string <= ns;
        do
            @(posedge clk);
        while (!req_ch.ready);
        reqs_sent++;
    endtask

    // Fields that a request type does not use carry random junk, so every
    // input bit toggles whatever the mix of requests.
    task automatic send_fmt(input logic [7:0] b, input logic fe);
        drive_req(RT_FMT, b, fe, $urandom, 1'($urandom_range(1)));
    endtask

    task automatic send_arg(input logic [31:0] v);
        drive_req(RT_ARG, 8'($urandom), 1'($urandom_range(1)), v, 1'($urandom_range(1)));
    endtask

    task automatic send_sbyte(input logic [7:0] b);
        drive_req(RT_SBYTE, b, 1'($urandom_range(1)), $urandom, 1'($urandom_range(1)));
    endtask

    task automatic send_str_end(input logic ns);
        drive_req(RT_SEND, 8'($urandom), 1'($urandom_range(1)), $urandom, ns);
    endtask

    // Drop valid and hold off until every predicted character has come out.
    task automatic drain_chars();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // Small values, small negatives and the edges of the 32-bit range, with
    // full-width noise half of the time.
    function automatic logic [31:0] pick_number();
        case ($urandom_range(5))
            0: return $urandom_range(9);
            1:
            begin
                case ($urandom_range(3))
                    0:       return 32'h8000_0000;
                    1:       return 32'hffff_ffff;
                    2:       return 32'h7fff_ffff;
                    default: return 32'h0000_0000;
                endcase
            end
            2:       return -32'($urandom_range(1, 100));
            default: return $urandom;
        endcase
    endfunction

    // Build one well-formed format of a few segments with random content; the
    // last format byte carries format_end. Now and then slip in a stray request
    // of any type to knock the parser off its sequence.
    task automatic random_format();
        int         n_seg;
        int         pick;
        int         n_bytes;
        logic       is_last;
        logic [7:0] b;
        n_seg = $urandom_range(1, 5);
        for (int s = 0; s < n_seg; s++)
        begin
            is_last = (s == n_seg - 1);
            if ($urandom_range(99) < 6)
                drive_req(2'($urandom_range(3)), 8'($urandom), 1'($urandom_range(1)),
                          $urandom, 1'($urandom_range(1)));
            pick = $urandom_range(99);
            if (pick < 25)
            begin
                b = 8'($urandom);
                if (b == CH_PCT)
                    b = b + 8'd1;
                send_fmt(b, is_last);
            end
            else if (pick < 60)
            begin
                send_fmt(CH_PCT, 1'b0);
                if (pick < 40)
                    send_fmt($urandom_range(1) ? CH_D : CH_I, is_last);
                else if (pick < 50)
                    send_fmt(CH_U, is_last);
                else
                    send_fmt(CH_X, is_last);
                send_arg(pick_number());
            end
            else if (pick < 68)
            begin
                send_fmt(CH_PCT, 1'b0);
                send_fmt(CH_C, is_last);
                send_arg($urandom);
            end
            else if (pick < 82)
            begin
                send_fmt(CH_PCT, 1'b0);
                send_fmt(CH_S, is_last);
                n_bytes = $urandom_range(4);
                for (int k = 0; k < n_bytes; k++)
                    send_sbyte(8'($urandom));
                send_str_end($urandom_range(6) == 0);
            end
            else if (pick < 88)
            begin
                // "%%": the held '%' is printed and the second is held again unless it ends the format
                send_fmt(CH_PCT, 1'b0);
                send_fmt(CH_PCT, is_last);
            end
            else if (pick < 94)
            begin
                b = 8'($urandom);
                if (b inside {CH_C, CH_D, CH_I, CH_U, CH_X, CH_S})
                    b = "z";
                send_fmt(CH_PCT, 1'b0);
                send_fmt(b, is_last);
            end
            else
            begin
                send_fmt(CH_PCT, is_last);
            end
        end
    endtask

    initial
    begin
        int base;
        req_ch.valid       <= 1'b0;
        req_ch.req_type    <= RT_FMT;
        req_ch.in_byte     <= 8'h00;
        req_ch.format_end  <= 1'b0;
        req_ch.arg_value   <= 32'h0;
        req_ch.null_string <= 1'b0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero byte as a plain character, every conversion at its
        // extremes, the most negative decimal, empty and null strings, a
        // non-conversion after '%', a trailing '%', and dropped requests.
        send_fmt(8'h00, 1'b0);
        send_fmt(CH_PCT, 1'b0);
        send_fmt(CH_D, 1'b0);
        send_arg(32'h8000_0000);
        send_fmt(CH_PCT, 1'b0);
        send_fmt(CH_U, 1'b0);
        send_arg(32'hffff_ffff);
        send_fmt(CH_PCT, 1'b0);
        send_fmt(CH_X, 1'b0);
        send_arg(32'h0);
        send_fmt(CH_PCT, 1'b0);
        send_fmt(CH_I, 1'b0);
        send_arg(32'h7fff_ffff);
        send_fmt(CH_PCT, 1'b0);
        send_fmt(CH_C, 1'b0);
        send_arg(32'hffff_ff7a);
        send_fmt(CH_PCT, 1'b0);
        send_fmt(CH_S, 1'b0);
        send_sbyte(8'hff);
        send_sbyte(8'h00);
        send_str_end(1'b0);
        send_fmt(CH_PCT, 1'b0);
        send_fmt(CH_S, 1'b0);
        send_str_end(1'b1);
        send_fmt(CH_PCT, 1'b0);
        send_fmt("q", 1'b0);
        send_fmt(CH_PCT, 1'b1);

        // wrong request types in each phase: idle, held '%', argument, string
        drive_req(RT_SEND, 8'h5a, 1'b1, 32'h1234_5678, 1'b1);
        send_fmt(CH_PCT, 1'b0);
        send_sbyte(8'h41);
        send_fmt(CH_X, 1'b0);
        send_fmt(8'h41, 1'b0);
        send_arg(32'hdead_beef);
        send_fmt(CH_PCT, 1'b0);
        send_fmt(CH_S, 1'b1);
        send_arg(32'h0);
        // empty non-null string closes the format: one uncounted zero character
        send_str_end(1'b0);

        // pause the sender until the block has emptied out
        drain_chars();

        // Random formats in three stretches: slow sender / slow receiver, the
        // other way round, then both at full rate.
        base = reqs_sent;
        for (int p = 0; p < 3; p++)
        begin
            snd_idle = (p == 0) ? 38 : (p == 1) ? 76 : 0;
            rcv_idle = (p == 0) ? 76 : (p == 1) ? 38 : 0;
            while (reqs_sent < base + (p + 1) * 113)
                random_format();
            drain_chars();
        end

        // let a last decimal conversion run out before the verdict
        repeat (60) @(posedge clk);

        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Guard against a hung handshake: far beyond the slowest correct run.
    initial
    begin
        #5000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

### printf_format_engine.f
design/pfe_pkg.sv
design/pfe_if.sv
design/pfe_front.sv
design/pfe_queue.sv
design/pfe_back.sv
design/printf_format_engine.sv
bench/pfe_char_checker.sv
bench/tb_printf_format_engine.sv
